// File: hw/rtl/s_curve_speed_ramp_defines.svh
// assertion helpers for the s-curve speed ramp
`ifndef S_CURVE_SPEED_RAMP_DEFINES_SVH
`define S_CURVE_SPEED_RAMP_DEFINES_SVH

// same-cycle implication
`define SCSR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scsr same-cycle check failed");

// next-cycle implication
`define SCSR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scsr next-cycle check failed");

`endif

// File: hw/rtl/scsr_pkg.sv
`timescale 1ns / 1ps

package scsr_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int ACCEL_RESET  = 500;
    localparam int THRESH_RESET = 128;

    localparam logic [FRAC_BITS:0] R_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // register indexes
    localparam logic REG_ACCEL  = 1'b0;
    localparam logic REG_THRESH = 1'b1;

endpackage

// File: hw/rtl/scsr_divider.sv
`timescale 1ns / 1ps

module scsr_divider #(
    parameter int W = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [W-1:0]                   i_dividend,
    input  logic [W-1:0]                   i_divisor,
    output logic [scsr_pkg::FRAC_BITS-1:0] o_quot,
    output logic                           o_done
);
    import scsr_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic [W-1:0]         r_rem;
    logic [W-1:0]         r_div;
    logic [FRAC_BITS-1:0] r_quot;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [W:0]   shifted;
    logic [W:0]   diffv;
    logic         ge;

    // one restoring step per cycle, dividend is below divisor
    assign shifted = {r_rem, 1'b0};
    assign diffv   = shifted - {1'b0, r_div};
    assign ge      = (shifted >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diffv[W-1:0] : shifted[W-1:0];
            r_quot <= {r_quot[FRAC_BITS-2:0], ge};
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

// File: hw/rtl/s_curve_speed_ramp.sv
`timescale 1ns / 1ps
`include "s_curve_speed_ramp_defines.svh"

// S-curve speed ramp. Each request on the s_axis side carries a signed Q8.8 target speed
// and yields one m_axis result: the planned speed and a ramp-done flag. A target change
// larger than retrigger_threshold restarts the ramp from the present speed; the speed then
// follows the smoothstep 3r^2-2r^3 of r = ticks/accel_ticks. One request at a time; the
// divider and the r^2 and r^3 passes are skipped once the ramp is done or accel_ticks is
// zero, and the block is ready again in the cycle after the result is loaded. While
// ramping, the 16-step serial divider for r and three passes through the one shared
// multiplier (r^2, r^3, blend) do the work; otherwise only the blend pass runs. A new
// request is accepted while the previous result still waits on m_axis_tready.
// Registers: accel_ticks at 0x0, retrigger_threshold at 0x4.
module s_curve_speed_ramp #(
    parameter int SPEED_BITS = 16,
    parameter int TIME_BITS  = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // cmd_speed
    input  logic [((SPEED_BITS+7)/8)*8-1:0]         s_axis_tdata,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // plan_speed, ramp_done
    output logic [((SPEED_BITS+8)/8)*8-1:0]         m_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [2:0]                              paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import scsr_pkg::*;

    localparam int OUT_W = ((SPEED_BITS + 8) / 8) * 8;
    localparam int MA_W  = (SPEED_BITS > FRAC_BITS) ? SPEED_BITS + 1 : FRAC_BITS + 1;
    localparam int MB_W  = FRAC_BITS + 2;
    localparam int SM_W  = FRAC_BITS + 3;
    localparam logic [TIME_BITS-1:0]  ACCEL_INIT  = TIME_BITS'(ACCEL_RESET);
    localparam logic [SPEED_BITS-2:0] THRESH_INIT = (SPEED_BITS-1)'(THRESH_RESET);

    typedef enum logic [3:0] {
        S_IDLE, S_CMP, S_CHECK, S_DIV, S_SQ, S_CUBE, S_SMOOTH, S_MULD, S_ADD, S_OUT
    } t_state;

    t_state r_state;

    logic [TIME_BITS-1:0]         r_accel;
    logic [SPEED_BITS-2:0]        r_thr;
    logic [TIME_BITS-1:0]         r_tick;
    logic signed [SPEED_BITS-1:0] r_target;
    logic signed [SPEED_BITS-1:0] r_prev;
    logic signed [SPEED_BITS-1:0] r_start;
    logic signed [SPEED_BITS-1:0] r_speed;
    logic [FRAC_BITS-1:0]         r_r;
    logic [FRAC_BITS-1:0]         r_r2;
    logic [FRAC_BITS-1:0]         r_r3;
    logic [FRAC_BITS:0]           r_s;
    logic signed [SPEED_BITS:0]   r_delta;
    logic                         r_ramp_done;
    logic signed [SPEED_BITS-1:0] r_out_speed;
    logic                         r_out_done;
    logic                         r_m_valid;

    logic                         cfg_wr;
    logic                         in_acc;
    logic signed [SPEED_BITS:0]   diff;
    logic signed [SPEED_BITS:0]   thr_s;
    logic                         retrig;
    logic                         div_start;
    logic [FRAC_BITS-1:0]         div_quot;
    logic                         div_done;
    logic signed [MA_W-1:0]       mul_a;
    logic signed [MB_W-1:0]       mul_b;
    logic signed [MA_W+MB_W-1:0]  mul_p;
    logic signed [SPEED_BITS:0]   span;
    logic signed [SM_W-1:0]       r2e;
    logic signed [SM_W-1:0]       r3e;
    logic signed [SM_W-1:0]       s_raw;
    logic [FRAC_BITS:0]           n_s;
    logic signed [SPEED_BITS:0]   sum;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_THRESH) ? 32'(r_thr) : 32'(r_accel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel <= ACCEL_INIT;
            r_thr   <= THRESH_INIT;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_ACCEL) begin
                r_accel <= pwdata[TIME_BITS-1:0];
            end else begin
                r_thr <= pwdata[SPEED_BITS-2:0];
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid & s_axis_tready;

    // retrigger test
    assign diff   = $signed({r_target[SPEED_BITS-1], r_target})
                  - $signed({r_prev[SPEED_BITS-1], r_prev});
    assign thr_s  = $signed({2'b00, r_thr});
    assign retrig = (diff > thr_s) || (diff < -thr_s);

    assign div_start = (r_state == S_CHECK) && (r_tick < r_accel);

    scsr_divider #(
        .W (TIME_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_tick),
        .i_divisor  (r_accel),
        .o_quot     (div_quot),
        .o_done     (div_done)
    );

    // shared multiplier
    assign span = $signed({r_target[SPEED_BITS-1], r_target})
                - $signed({r_start[SPEED_BITS-1], r_start});

    always_comb begin
        case (r_state)
            S_SQ: begin
                mul_a = $signed(MA_W'(r_r));
                mul_b = $signed(MB_W'(r_r));
            end
            S_CUBE: begin
                mul_a = $signed(MA_W'(r_r2));
                mul_b = $signed(MB_W'(r_r));
            end
            default: begin
                mul_a = MA_W'(span);
                mul_b = $signed(MB_W'(r_s));
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // smoothstep with clamp
    assign r2e   = $signed(SM_W'(r_r2));
    assign r3e   = $signed(SM_W'(r_r3));
    assign s_raw = (r2e <<< 1) + r2e - (r3e <<< 1);

    always_comb begin
        if (s_raw < 0) begin
            n_s = '0;
        end else if (s_raw > $signed(SM_W'(R_ONE))) begin
            n_s = R_ONE;
        end else begin
            n_s = s_raw[FRAC_BITS:0];
        end
    end

    assign sum = $signed({r_start[SPEED_BITS-1], r_start}) + r_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tick    <= '0;
            r_prev    <= '0;
            r_start   <= '0;
            r_speed   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_m_valid && m_axis_tready && (r_state != S_OUT)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_target <= $signed(s_axis_tdata[SPEED_BITS-1:0]);
                        r_state  <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (retrig) begin
                        r_tick  <= '0;
                        r_start <= r_speed;
                    end else if (r_tick < r_accel) begin
                        r_tick <= r_tick + TIME_BITS'(1);
                    end
                    r_prev  <= r_target;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_tick < r_accel) begin
                        r_state <= S_DIV;
                    end else begin
                        r_s     <= R_ONE;
                        r_state <= S_MULD;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_r     <= div_quot;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_r2    <= mul_p[FRAC_BITS +: FRAC_BITS];
                    r_state <= S_CUBE;
                end
                S_CUBE: begin
                    r_r3    <= mul_p[FRAC_BITS +: FRAC_BITS];
                    r_state <= S_SMOOTH;
                end
                S_SMOOTH: begin
                    r_s     <= n_s;
                    r_state <= S_MULD;
                end
                S_MULD: begin
                    r_delta <= mul_p[FRAC_BITS +: SPEED_BITS+1];
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_speed     <= sum[SPEED_BITS-1:0];
                    r_ramp_done <= (r_tick >= r_accel);
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_out_speed <= r_speed;
                        r_out_done  <= r_ramp_done;
                        r_m_valid   <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_W'({r_out_done, r_out_speed});

    `SCSR_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, div_done, r_state == S_DIV)
    `SCSR_ASSERT_IMP(a_blend_in_range, i_clk, i_rst_n, r_state == S_MULD, r_s <= R_ONE)
    `SCSR_ASSERT_NXT(a_retrig_clears, i_clk, i_rst_n, (r_state == S_CMP) && retrig, r_tick == '0)

endmodule
